FILE: hdl/round_robin_completion_times_unit_assert.svh
// assertion macros used by the round-robin scheduler module
`ifndef ROUND_ROBIN_COMPLETION_TIMES_UNIT_ASSERT_SVH
`define ROUND_ROBIN_COMPLETION_TIMES_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RRCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RRCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rrct_pkg.sv
package rrct_pkg;

  // default sizing of the job store
  localparam int MAX_JOBS_DEF    = 16;
  localparam int BURST_WIDTH_DEF = 16;

  // fixed field widths of the channels
  localparam int BURST_IN_W  = 16;
  localparam int QUANTUM_W   = 16;
  localparam int INDEX_OUT_W = 4;
  localparam int TIME_OUT_W  = 20;
  localparam int SUM_W       = 24;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  // register map, index taken from paddr above the byte offset
  localparam logic [REG_IDX_W-1:0] REG_TIME_QUANTUM = 1'b0;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

endpackage

FILE: hdl/rrct_if.sv
// job load channel
interface rrct_job_if;
  logic                              valid;
  logic                              ready;
  logic [rrct_pkg::BURST_IN_W-1:0]   burst_time;
  logic                              last_job;

  modport source (output valid, output burst_time, output last_job, input ready);
  modport sink   (input valid, input burst_time, input last_job, output ready);
endinterface

// per-job result channel
interface rrct_result_if;
  logic                              valid;
  logic                              ready;
  logic [rrct_pkg::INDEX_OUT_W-1:0]  job_index;
  logic [rrct_pkg::BURST_IN_W-1:0]   job_burst;
  logic [rrct_pkg::TIME_OUT_W-1:0]   turnaround_time;
  logic [rrct_pkg::TIME_OUT_W-1:0]   waiting_time;
  logic [rrct_pkg::SUM_W-1:0]        total_turnaround;
  logic [rrct_pkg::SUM_W-1:0]        total_waiting;
  logic                              last_result;

  modport source (output valid, output job_index, output job_burst, output turnaround_time,
                  output waiting_time, output total_turnaround, output total_waiting,
                  output last_result, input ready);
  modport sink   (input valid, input job_index, input job_burst, input turnaround_time,
                  input waiting_time, input total_turnaround, input total_waiting,
                  input last_result, output ready);
endinterface

FILE: hdl/rrct_ram.sv
module rrct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rrct_cfg.sv
module rrct_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rrct_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [rrct_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [rrct_pkg::APB_DATA_W-1:0]      prdata,
  output logic [rrct_pkg::QUANTUM_W-1:0]       time_quantum
);

  logic [rrct_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_hit;

  // register index sits above the byte offset
  assign reg_idx = paddr[rrct_pkg::APB_ADDR_W-1 -: rrct_pkg::REG_IDX_W];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == rrct_pkg::REG_TIME_QUANTUM);

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum <= rrct_pkg::QUANTUM_RESET;
    end else if (wr_hit) begin
      time_quantum <= pwdata[rrct_pkg::QUANTUM_W-1:0];
    end
  end

  // read decode
  always_comb begin
    unique case (reg_idx)
      rrct_pkg::REG_TIME_QUANTUM: prdata = rrct_pkg::APB_DATA_W'(time_quantum);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: hdl/rrct_sched.sv
`include "round_robin_completion_times_unit_assert.svh"

module rrct_sched #(
  parameter int MAX_JOBS    = rrct_pkg::MAX_JOBS_DEF,
  parameter int BURST_WIDTH = rrct_pkg::BURST_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rrct_pkg::QUANTUM_W-1:0] time_quantum,
  rrct_job_if.sink                       job,
  rrct_result_if.source                  result
);

  localparam int STORE_W = (BURST_WIDTH < rrct_pkg::BURST_IN_W) ? BURST_WIDTH
                                                                : rrct_pkg::BURST_IN_W;
  localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W   = $clog2(MAX_JOBS + 1);
  localparam int CLK_W   = STORE_W + CNT_W;
  localparam int WORD_W  = 2 * STORE_W + CLK_W;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EX   = 3'd2;
  localparam logic [2:0] S_ORD  = 3'd3;
  localparam logic [2:0] S_OV   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [CLK_W-1:0]  clock_value;
  logic              any_left;
  logic [rrct_pkg::SUM_W-1:0] sum_tt;
  logic [rrct_pkg::SUM_W-1:0] sum_wt;
  logic              out_valid;

  logic                           in_fire;
  logic                           store_ok;
  logic                           last_idx;
  logic [IDX_W-1:0]               idx_inc;
  logic [STORE_W-1:0]             in_burst;
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [WORD_W-1:0]              ram_wdata;
  logic [WORD_W-1:0]              ram_rdata;
  logic [STORE_W-1:0]             rd_burst;
  logic [STORE_W-1:0]             rd_rem;
  logic [CLK_W-1:0]               rd_finish;
  logic [rrct_pkg::QUANTUM_W-1:0] q_eff;
  logic [rrct_pkg::QUANTUM_W-1:0] rem_ext;
  logic [rrct_pkg::QUANTUM_W-1:0] take_w;
  logic [STORE_W-1:0]             take;
  logic [STORE_W-1:0]             rem_new;
  logic [CLK_W-1:0]               clock_step;
  logic [CLK_W-1:0]               fin_new;
  logic [CLK_W-1:0]               tt_full;
  logic [CLK_W-1:0]               wt_full;
  logic [rrct_pkg::SUM_W-1:0]     sum_tt_next;
  logic [rrct_pkg::SUM_W-1:0]     sum_wt_next;

  // handshake and bookkeeping
  assign in_fire  = job.valid && job.ready;
  assign job.ready = (state == S_LOAD);
  assign store_ok = (count < CNT_W'(MAX_JOBS));
  assign last_idx = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign idx_inc  = idx + IDX_W'(1);
  assign in_burst = job.burst_time[STORE_W-1:0];

  // store word is {burst, remaining, finish}
  assign rd_burst  = ram_rdata[WORD_W-1 -: STORE_W];
  assign rd_rem    = ram_rdata[CLK_W+STORE_W-1 -: STORE_W];
  assign rd_finish = ram_rdata[CLK_W-1:0];

  // shared slice unit: min(remaining, quantum), subtract, advance clock
  always_comb begin
    q_eff      = (time_quantum == '0) ? rrct_pkg::QUANTUM_W'(1) : time_quantum;
    rem_ext    = rrct_pkg::QUANTUM_W'(rd_rem);
    take_w     = (rem_ext > q_eff) ? q_eff : rem_ext;
    take       = STORE_W'(take_w);
    rem_new    = rd_rem - take;
    clock_step = clock_value + CLK_W'(take);
    fin_new    = (rem_new == '0) ? clock_step : rd_finish;
  end

  // result values, zero burst reports zero times
  always_comb begin
    tt_full     = (rd_burst == '0) ? '0 : rd_finish;
    wt_full     = tt_full - CLK_W'(rd_burst);
    sum_tt_next = sum_tt + rrct_pkg::SUM_W'(tt_full);
    sum_wt_next = sum_wt + rrct_pkg::SUM_W'(wt_full);
  end

  // store write port: loads while idle, write-back during the sweep
  always_comb begin
    if (state == S_LOAD) begin
      ram_we    = in_fire && store_ok;
      ram_waddr = count[IDX_W-1:0];
      ram_wdata = {in_burst, in_burst, {CLK_W{1'b0}}};
    end else begin
      ram_we    = (state == S_EX) && (rd_rem != '0);
      ram_waddr = idx;
      ram_wdata = {rd_burst, rem_new, fin_new};
    end
  end

  rrct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: if (in_fire && job.last_job) state_next = S_RD;
      S_RD:   state_next = S_EX;
      S_EX: begin
        if (last_idx && !(any_left || (rem_new != '0))) begin
          state_next = S_ORD;
        end else begin
          state_next = S_RD;
        end
      end
      S_ORD:  if (!out_valid || result.ready) state_next = S_OV;
      S_OV:   state_next = last_idx ? S_LOAD : S_ORD;
      default: state_next = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      idx         <= '0;
      count       <= '0;
      clock_value <= '0;
      any_left    <= 1'b0;
      sum_tt      <= '0;
      sum_wt      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (store_ok) begin
              count <= count + CNT_W'(1);
            end
            if (job.last_job) begin
              idx         <= '0;
              clock_value <= '0;
              any_left    <= 1'b0;
              sum_tt      <= '0;
              sum_wt      <= '0;
            end
          end
        end
        S_RD: begin
        end
        S_EX: begin
          if (rd_rem != '0) begin
            clock_value <= clock_step;
          end
          if (last_idx) begin
            idx      <= '0;
            any_left <= 1'b0;
          end else begin
            idx      <= idx_inc;
            any_left <= any_left || (rem_new != '0);
          end
        end
        S_ORD: begin
        end
        S_OV: begin
          out_valid <= 1'b1;
          sum_tt    <= sum_tt_next;
          sum_wt    <= sum_wt_next;
          if (last_idx) begin
            idx         <= '0;
            count       <= '0;
            clock_value <= '0;
          end else begin
            idx <= idx_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (state == S_OV) begin
      result.job_index        <= rrct_pkg::INDEX_OUT_W'(idx);
      result.job_burst        <= rrct_pkg::BURST_IN_W'(rd_burst);
      result.turnaround_time  <= rrct_pkg::TIME_OUT_W'(tt_full);
      result.waiting_time     <= rrct_pkg::TIME_OUT_W'(wt_full);
      result.total_turnaround <= last_idx ? sum_tt_next : '0;
      result.total_waiting    <= last_idx ? sum_wt_next : '0;
      result.last_result      <= last_idx;
    end
  end

  assign result.valid = out_valid;

  // checks
  `RRCT_ASSERT_NEXT(a_run_start, clk, rst, in_fire && job.last_job, state == S_RD,
                    "last job did not start the sweep")
  `RRCT_ASSERT_SAME(a_slot_free, clk, rst, state == S_OV, !out_valid,
                    "result register still busy when loading a result")
  `RRCT_ASSERT_NEXT(a_result_load, clk, rst, state == S_OV, out_valid,
                    "result not presented after load")
  `RRCT_ASSERT_NEXT(a_run_end, clk, rst, (state == S_OV) && last_idx,
                    (state == S_LOAD) && (count == '0), "run did not return to loading")

endmodule

FILE: hdl/round_robin_completion_times_unit.sv
// loading: one job per cycle, ready while no run is in progress
// run: each job takes a read state and an execute state per round through one slice
//   unit and the job store; rounds = ceil(largest burst / quantum), at least one
// results: a read state and an output state per job via the store read port, plus output stalls
// reset (rst, synchronous, active high) clears the quantum to 4, the job count,
//   clock, totals and the output valid; job store contents are not cleared
module round_robin_completion_times_unit #(
  parameter int MAX_JOBS    = rrct_pkg::MAX_JOBS_DEF,
  parameter int BURST_WIDTH = rrct_pkg::BURST_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rrct_job_if.sink                        job,
  rrct_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrct_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rrct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rrct_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [rrct_pkg::QUANTUM_W-1:0] time_quantum;

  // zero wait state register port
  assign pready = 1'b1;

  rrct_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .time_quantum (time_quantum)
  );

  rrct_sched #(
    .MAX_JOBS    (MAX_JOBS),
    .BURST_WIDTH (BURST_WIDTH)
  ) u_sched (
    .clk          (clk),
    .rst          (rst),
    .time_quantum (time_quantum),
    .job          (job),
    .result       (result)
  );

endmodule
